@@ rtl/core/tdpg_pkg.sv @@
// Shared constants, types and seed table for the trial-division prime generator.
`default_nettype none

package tdpg_pkg;

   // Value and table geometry
   localparam int VALUE_BITS  = 20;
   localparam int TABLE_DEPTH = 4096;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   // Counts and positions are 13 bits wide (they reach the table depth)
   localparam int CNT_BITS    = 13;
   localparam int LIMIT_BITS  = 13;
   localparam int SQ_BITS     = 2 * VALUE_BITS;
   localparam int STEP_BITS   = $clog2(VALUE_BITS);

   localparam int SEED_COUNT     = 4;
   localparam int SEED_IDX_BITS  = 2;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET  = LIMIT_BITS'(4096);
   localparam logic [CNT_BITS-1:0]   DEPTH_COUNT  = CNT_BITS'(TABLE_DEPTH);
   localparam logic [CNT_BITS-1:0]   SEED_FOUND   = CNT_BITS'(SEED_COUNT);
   localparam logic [VALUE_BITS-1:0] CAND_RESET   = VALUE_BITS'(7);
   localparam logic [VALUE_BITS-1:0] VALUE_MAX    = {VALUE_BITS{1'b1}};
   localparam logic [VALUE_BITS-1:0] CAND_MAX     = VALUE_MAX - VALUE_BITS'(2);
   localparam logic [VALUE_BITS-1:0] CAND_STEP    = VALUE_BITS'(2);

   // Table write word
   typedef struct packed {
      logic                  en;
      logic [IDX_BITS-1:0]   addr;
      logic [VALUE_BITS-1:0] data;
   } tbl_write_type;

   // Remainder unit status
   typedef struct packed {
      logic done;
      logic zero;
   } rem_status_type;

   // First four primes, held outside the memory
   function automatic logic [VALUE_BITS-1:0] seed_value(input logic [SEED_IDX_BITS-1:0] idx);
      logic [VALUE_BITS-1:0] val;
      case (idx)
         2'd0:    val = VALUE_BITS'(2);
         2'd1:    val = VALUE_BITS'(3);
         2'd2:    val = VALUE_BITS'(5);
         2'd3:    val = VALUE_BITS'(7);
         default: val = VALUE_BITS'(2);
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/trial_division_prime_generator_core.sv @@
// A done word goes IDLE, DISPATCH, FINISH to the output register; a seed prime adds SEED_DATA.
// A new prime goes, per divisor tried, through table read, square, compare, then the
// bit-serial remainder unit (TRY, LOAD, SQUARE, TEST, DIVIDE), repeated over all candidates.
// Throughput: one word at a time; the next request is taken while a result waits.
// Reset: synchronous; table holds seeds 2,3,5,7, limit 4096, no clearing pass.
`default_nettype none

module trial_division_prime_generator_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_restart,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [tdpg_pkg::VALUE_BITS-1:0]   rsp_prime_value,
   output logic      [tdpg_pkg::CNT_BITS-1:0]     rsp_prime_position,
   output logic                                   rsp_done_res,
   // configuration
   input  wire logic                              csr_wr_en,
   input  wire logic [tdpg_pkg::LIMIT_BITS-1:0]   csr_wr_data
);

   localparam int VB = tdpg_pkg::VALUE_BITS;
   localparam int CB = tdpg_pkg::CNT_BITS;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_DISPATCH  = 9'b000000010,
      ST_SEED_DATA = 9'b000000100,
      ST_TRY       = 9'b000001000,
      ST_LOAD      = 9'b000010000,
      ST_SQUARE    = 9'b000100000,
      ST_TEST      = 9'b001000000,
      ST_DIVIDE    = 9'b010000000,
      ST_FINISH    = 9'b100000000
   } state_type;

   state_type                          state_ff, state_in;
   logic [tdpg_pkg::LIMIT_BITS-1:0]    limit_ff, limit_in;
   logic [CB-1:0]                      found_ff, found_in;
   logic [CB-1:0]                      given_ff, given_in;
   logic [VB-1:0]                      cand_ff, cand_in;
   logic [VB-1:0]                      test_ff, test_in;
   logic [CB-1:0]                      idx_ff, idx_in;
   logic [VB-1:0]                      p_ff, p_in;
   logic [tdpg_pkg::SQ_BITS-1:0]       sq_ff, sq_in;
   logic [VB-1:0]                      res_value_ff, res_value_in;
   logic [CB-1:0]                      res_pos_ff, res_pos_in;
   logic                               res_done_ff, res_done_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [VB-1:0]                      rsp_value_ff, rsp_value_in;
   logic [CB-1:0]                      rsp_pos_ff, rsp_pos_in;
   logic                               rsp_done_ff, rsp_done_in;

   logic [CB-1:0]                      limit_eff;
   logic [tdpg_pkg::IDX_BITS-1:0]      rd_addr;
   logic [VB-1:0]                      rd_data;
   tdpg_pkg::tbl_write_type            tbl_wr;
   logic                               div_start;
   tdpg_pkg::rem_status_type           div_status;
   logic                               prime_hit;
   logic                               give_done;
   logic                               req_take;

   tdpg_table u_table (
      .clock   (clock),
      .rd_addr (rd_addr),
      .wr      (tbl_wr),
      .rd_data (rd_data)
   );

   tdpg_remainder u_remainder (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (test_ff),
      .divisor  (p_ff),
      .status   (div_status)
   );

   // Effective limit is capped at the table depth
   assign limit_eff = (limit_ff > tdpg_pkg::DEPTH_COUNT) ? tdpg_pkg::DEPTH_COUNT : limit_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rd_addr   = (state_ff == ST_DISPATCH) ? given_ff[tdpg_pkg::IDX_BITS-1:0]
                                                : idx_ff[tdpg_pkg::IDX_BITS-1:0];
   assign sq_in     = p_ff * p_ff;

   // New primes are appended at the found count
   assign tbl_wr.en   = prime_hit;
   assign tbl_wr.addr = found_ff[tdpg_pkg::IDX_BITS-1:0];
   assign tbl_wr.data = test_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      found_in     = found_ff;
      given_in     = given_ff;
      cand_in      = cand_ff;
      test_in      = test_ff;
      idx_in       = idx_ff;
      p_in         = p_ff;
      res_value_in = res_value_ff;
      res_pos_in   = res_pos_ff;
      res_done_in  = res_done_ff;
      div_start    = 1'b0;
      prime_hit    = 1'b0;
      give_done    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_restart) begin
                  found_in = tdpg_pkg::SEED_FOUND;
                  given_in = '0;
                  cand_in  = tdpg_pkg::CAND_RESET;
               end
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (given_ff >= limit_eff) begin
               give_done = 1'b1;
            end else if (given_ff < found_ff) begin
               state_in = ST_SEED_DATA;
            end else if (cand_ff > tdpg_pkg::CAND_MAX) begin
               give_done = 1'b1;
            end else begin
               test_in  = cand_ff + tdpg_pkg::CAND_STEP;
               idx_in   = CB'(1);
               state_in = ST_TRY;
            end
         end
         ST_SEED_DATA: begin
            res_value_in = rd_data;
            res_pos_in   = given_ff;
            res_done_in  = 1'b0;
            given_in     = given_ff + CB'(1);
            state_in     = ST_FINISH;
         end
         ST_TRY: begin
            // Divisors exhausted: prime
            if (idx_ff >= found_ff) begin
               prime_hit = 1'b1;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            p_in = rd_data;
            if (rd_data == '0) begin
               prime_hit = 1'b1;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if ({{VB{1'b0}}, test_ff} < sq_ff) begin
               prime_hit = 1'b1;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               if (div_status.zero) begin
                  // Composite: step to the next odd candidate
                  if (test_ff > tdpg_pkg::CAND_MAX) begin
                     give_done = 1'b1;
                  end else begin
                     test_in  = test_ff + tdpg_pkg::CAND_STEP;
                     idx_in   = CB'(1);
                     state_in = ST_TRY;
                  end
               end else begin
                  idx_in   = idx_ff + CB'(1);
                  state_in = ST_TRY;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Accept a found prime
      if (prime_hit) begin
         cand_in      = test_ff;
         found_in     = found_ff + CB'(1);
         given_in     = given_ff + CB'(1);
         res_value_in = test_ff;
         res_pos_in   = given_ff;
         res_done_in  = 1'b0;
         state_in     = ST_FINISH;
      end

      // Done word
      if (give_done) begin
         res_value_in = '0;
         res_pos_in   = '0;
         res_done_in  = 1'b1;
         state_in     = ST_FINISH;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_done_in  = rsp_done_ff;
      if ((state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res_value_ff;
         rsp_pos_in   = res_pos_ff;
         rsp_done_in  = res_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= tdpg_pkg::LIMIT_RESET;
         found_ff     <= tdpg_pkg::SEED_FOUND;
         given_ff     <= '0;
         cand_ff      <= tdpg_pkg::CAND_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         found_ff     <= found_in;
         given_ff     <= given_in;
         cand_ff      <= cand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      test_ff      <= test_in;
      idx_ff       <= idx_in;
      p_ff         <= p_in;
      sq_ff        <= sq_in;
      res_value_ff <= res_value_in;
      res_pos_ff   <= res_pos_in;
      res_done_ff  <= res_done_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_prime_value    = rsp_value_ff;
   assign rsp_prime_position = rsp_pos_ff;
   assign rsp_done_res       = rsp_done_ff;

endmodule

`default_nettype wire

@@ rtl/core/tdpg_table.sv @@
// Prime table: synchronous RAM with a fixed overlay for the four seed primes.
`default_nettype none

module tdpg_table (
   input  wire logic                            clock,
   input  wire logic [tdpg_pkg::IDX_BITS-1:0]   rd_addr,
   input  wire tdpg_pkg::tbl_write_type         wr,
   output logic      [tdpg_pkg::VALUE_BITS-1:0] rd_data
);

   logic [tdpg_pkg::VALUE_BITS-1:0]    mem [tdpg_pkg::TABLE_DEPTH];
   logic [tdpg_pkg::VALUE_BITS-1:0]    rd_data_ff;
   logic                               rd_seed_ff;
   logic [tdpg_pkg::SEED_IDX_BITS-1:0] rd_idx_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
      rd_seed_ff <= (rd_addr < tdpg_pkg::IDX_BITS'(tdpg_pkg::SEED_COUNT));
      rd_idx_ff  <= rd_addr[tdpg_pkg::SEED_IDX_BITS-1:0];
   end

   // Seed entries never live in the RAM
   assign rd_data = rd_seed_ff ? tdpg_pkg::seed_value(rd_idx_ff) : rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/tdpg_remainder.sv @@
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`default_nettype none

module tdpg_remainder (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [tdpg_pkg::VALUE_BITS-1:0] dividend,
   input  wire logic [tdpg_pkg::VALUE_BITS-1:0] divisor,
   output tdpg_pkg::rem_status_type             status
);

   localparam int VB = tdpg_pkg::VALUE_BITS;

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic                              zero_ff, zero_in;
   logic [tdpg_pkg::STEP_BITS-1:0]    step_ff, step_in;
   logic [VB-1:0]                     rem_ff, rem_in;
   logic [VB-1:0]                     num_ff, num_in;
   logic [VB-1:0]                     div_ff, div_in;
   logic [VB:0]                       shifted;
   logic [VB:0]                       diff;
   logic [VB-1:0]                     rem_next;

   // One restoring step
   always_comb begin
      shifted  = {rem_ff, num_ff[VB-1]};
      diff     = shifted - {1'b0, div_ff};
      rem_next = (shifted >= {1'b0, div_ff}) ? diff[VB-1:0] : shifted[VB-1:0];
   end

   // Step sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = tdpg_pkg::STEP_BITS'(VB - 1);
         rem_in  = '0;
         num_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = rem_next;
         num_in  = {num_ff[VB-2:0], 1'b0};
         step_in = step_ff - tdpg_pkg::STEP_BITS'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            zero_in = (rem_next == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      zero_ff <= zero_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      div_ff  <= div_in;
   end

   assign status.done = done_ff;
   assign status.zero = zero_ff;

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for trial_division_prime_generator_core.
module tb;

   // one result word as it leaves the block
   typedef struct packed {
      logic [tdpg_pkg::VALUE_BITS-1:0] value;
      logic [tdpg_pkg::CNT_BITS-1:0]   pos;
      logic                            done;
   } prime_word_type;

   typedef enum logic {ROW_REQ, ROW_CFG} row_kind_type;

   // one row of the directed stimulus
   typedef struct packed {
      row_kind_type                    kind;
      logic [tdpg_pkg::LIMIT_BITS-1:0] cfg_val;
      logic                            restart;
      logic                            typed;
      prime_word_type                  word;
   } dir_row_type;

   localparam int                              DIR_ROWS  = 25;
   localparam int                              PHASES    = 5;
   localparam int                              PHASE_LEN = 85;
   localparam int                              MAX_SHOWN = 10;
   localparam logic [tdpg_pkg::LIMIT_BITS-1:0] LIM_TOP   = tdpg_pkg::LIMIT_BITS'(4096);
   localparam logic [tdpg_pkg::LIMIT_BITS-1:0] LIM_LOW   = tdpg_pkg::LIMIT_BITS'(5);
   localparam prime_word_type DONE_WORD = '{value: '0, pos: '0, done: 1'b1};

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_restart = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [tdpg_pkg::VALUE_BITS-1:0] rsp_prime_value;
   logic [tdpg_pkg::CNT_BITS-1:0]   rsp_prime_position;
   logic                            rsp_done_res;
   logic                            csr_wr_en = 1'b0;
   logic [tdpg_pkg::LIMIT_BITS-1:0] csr_wr_data = '0;

   // predictor state
   logic [tdpg_pkg::VALUE_BITS-1:0] prime_tab [tdpg_pkg::TABLE_DEPTH];
   int unsigned                     found_cnt;
   int unsigned                     given_cnt;
   logic [tdpg_pkg::VALUE_BITS-1:0] last_cand;
   logic [tdpg_pkg::LIMIT_BITS-1:0] limit_reg;

   prime_word_type pending_words [$];
   int             mismatch_cnt = 0;
   logic           send_calm = 1'b0;
   logic           recv_calm = 1'b0;
   dir_row_type    dir_rows [DIR_ROWS];

   trial_division_prime_generator_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_prime_value    (rsp_prime_value),
      .rsp_prime_position (rsp_prime_position),
      .rsp_done_res       (rsp_done_res),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop
   initial begin
      #100_000_000;
      $display("trial_division_prime_generator_core: mismatch");
      $finish;
   end

   function automatic void reseed_table();
      prime_tab[0] = tdpg_pkg::VALUE_BITS'(2);
      prime_tab[1] = tdpg_pkg::VALUE_BITS'(3);
      prime_tab[2] = tdpg_pkg::VALUE_BITS'(5);
      prime_tab[3] = tdpg_pkg::VALUE_BITS'(7);
      found_cnt    = 4;
      given_cnt    = 0;
      last_cand    = tdpg_pkg::VALUE_BITS'(7);
   endfunction

   // trial division by stored primes from 3 upward
   function automatic logic cand_is_prime(input longint unsigned v);
      longint unsigned p;
      for (int unsigned i = 1; i < found_cnt && i < tdpg_pkg::TABLE_DEPTH; i++) begin
         p = prime_tab[i];
         if (p == 0) return 1'b1;
         if (v < p * p) return 1'b1;
         if (v % p == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // next word for one accepted request; advances the predictor state
   function automatic prime_word_type next_prime_word(input logic restart);
      prime_word_type  w;
      int unsigned     lim;
      longint unsigned c;
      longint unsigned vmax;
      w    = DONE_WORD;
      vmax = (64'd1 << tdpg_pkg::VALUE_BITS) - 1;
      lim  = (limit_reg < tdpg_pkg::TABLE_DEPTH) ? limit_reg : tdpg_pkg::TABLE_DEPTH;
      if (restart) reseed_table();
      if (given_cnt >= lim) begin
         return w;
      end
      if (given_cnt < found_cnt) begin
         w = '{value: prime_tab[given_cnt], pos: tdpg_pkg::CNT_BITS'(given_cnt),
               done: 1'b0};
         given_cnt++;
         return w;
      end
      c = last_cand;
      forever begin
         // next odd candidate would not fit: done, state kept
         if (c > vmax - 2) return w;
         c = c + 2;
         if (cand_is_prime(c)) break;
      end
      last_cand            = tdpg_pkg::VALUE_BITS'(c);
      prime_tab[found_cnt] = tdpg_pkg::VALUE_BITS'(c);
      found_cnt++;
      w = '{value: tdpg_pkg::VALUE_BITS'(c), pos: tdpg_pkg::CNT_BITS'(given_cnt),
            done: 1'b0};
      given_cnt++;
      return w;
   endfunction

   // present one request word, predict at acceptance, then idle a while
   task automatic issue_word(input logic restart, input logic typed,
                             input prime_word_type typed_word);
      prime_word_type guess;
      int             gap;
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      guess = next_prime_word(restart);
      pending_words.push_back(typed ? typed_word : guess);
      gap = send_calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // limit write with the block drained
   task automatic write_limit(input logic [tdpg_pkg::LIMIT_BITS-1:0] val);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      limit_reg = val;
      csr_wr_en <= 1'b0;
   endtask

   // result side: random stalls, compare against the oldest expectation
   initial begin
      prime_word_type want;
      prime_word_type got;
      int             stall;
      int             words;
      words = 0;
      wait (!reset);
      forever begin
         if (words % 40 == 0) recv_calm = ($urandom_range(0, 3) == 0);
         stall = recv_calm ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         words++;
         got = '{value: rsp_prime_value, pos: rsp_prime_position, done: rsp_done_res};
         if (pending_words.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_SHOWN)
               $display("unexpected word: value %0d pos %0d done %0d",
                        got.value, got.pos, got.done);
         end else begin
            want = pending_words.pop_front();
            if (got !== want) begin
               mismatch_cnt++;
               if (mismatch_cnt <= MAX_SHOWN)
                  $display("word %0d: expected value %0d pos %0d done %0d, got %0d %0d %0d",
                           words, want.value, want.pos, want.done,
                           got.value, got.pos, got.done);
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [tdpg_pkg::LIMIT_BITS-1:0] lim;
      int                              odds;
      int                              sent;
      int                              waited;

      limit_reg = LIM_TOP;
      reseed_table();

      // seeds, first computed primes, restarts, limit edges, limit lowered mid-run
      dir_rows = '{
         '{ROW_REQ, '0, 1'b0, 1'b1, '{20'd2, 13'd0, 1'b0}},
         '{ROW_REQ, '0, 1'b0, 1'b1, '{20'd3, 13'd1, 1'b0}},
         '{ROW_REQ, '0, 1'b0, 1'b1, '{20'd5, 13'd2, 1'b0}},
         '{ROW_REQ, '0, 1'b0, 1'b1, '{20'd7, 13'd3, 1'b0}},
         '{ROW_REQ, '0, 1'b0, 1'b0, '0},
         '{ROW_REQ, '0, 1'b0, 1'b0, '0},
         '{ROW_REQ, '0, 1'b1, 1'b1, '{20'd2, 13'd0, 1'b0}},
         '{ROW_REQ, '0, 1'b0, 1'b1, '{20'd3, 13'd1, 1'b0}},
         '{ROW_CFG, LIM_LOW, 1'b0, 1'b0, '0},
         '{ROW_REQ, '0, 1'b0, 1'b1, '{20'd5, 13'd2, 1'b0}},
         '{ROW_REQ, '0, 1'b0, 1'b1, '{20'd7, 13'd3, 1'b0}},
         '{ROW_REQ, '0, 1'b0, 1'b0, '0},
         '{ROW_REQ, '0, 1'b0, 1'b1, DONE_WORD},
         '{ROW_REQ, '0, 1'b1, 1'b1, '{20'd2, 13'd0, 1'b0}},
         '{ROW_CFG, '0, 1'b0, 1'b0, '0},
         '{ROW_REQ, '0, 1'b0, 1'b1, DONE_WORD},
         '{ROW_REQ, '0, 1'b1, 1'b1, DONE_WORD},
         '{ROW_CFG, '1, 1'b0, 1'b0, '0},
         '{ROW_REQ, '0, 1'b0, 1'b1, '{20'd2, 13'd0, 1'b0}},
         '{ROW_REQ, '0, 1'b0, 1'b1, '{20'd3, 13'd1, 1'b0}},
         '{ROW_CFG, 13'd1, 1'b0, 1'b0, '0},
         '{ROW_REQ, '0, 1'b0, 1'b1, DONE_WORD},
         '{ROW_CFG, LIM_TOP, 1'b0, 1'b0, '0},
         '{ROW_REQ, '0, 1'b0, 1'b0, '0},
         '{ROW_REQ, '0, 1'b1, 1'b1, '{20'd2, 13'd0, 1'b0}}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      for (int r = 0; r < DIR_ROWS; r++) begin
         if (dir_rows[r].kind == ROW_CFG) write_limit(dir_rows[r].cfg_val);
         else issue_word(dir_rows[r].restart, dir_rows[r].typed, dir_rows[r].word);
      end

      // random phases, each under its own limit
      sent = 0;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       lim = LIM_TOP;
            1:       lim = LIM_LOW;
            2:       lim = tdpg_pkg::LIMIT_BITS'($urandom_range(6, 60));
            3:       lim = '1;
            default: lim = tdpg_pkg::LIMIT_BITS'($urandom_range(0, 8191));
         endcase
         // long runs without restart in the first phase reach deeper primes
         odds = (ph == 0) ? 64 : 12;
         write_limit(lim);
         for (int n = 0; n < PHASE_LEN; n++) begin
            if (sent % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
            sent++;
            issue_word($urandom_range(0, odds - 1) == 0, 1'b0, '0);
         end
      end

      // drain
      req_valid <= 1'b0;
      waited = 0;
      while (pending_words.size() != 0 && waited < 2_000_000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (mismatch_cnt == 0 && pending_words.size() == 0) begin
         $display("trial_division_prime_generator_core: match");
      end else begin
         $display("trial_division_prime_generator_core: mismatch");
      end
      $finish;
   end

endmodule
